>>> rtl/mvna_pkg.sv
package mvna_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_FACE  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam int IDX_W   = 10;
	localparam int COORD_W = 24;
	localparam int NORM_W  = 16;

	typedef struct packed {
		logic [1:0]               opcode;
		logic [IDX_W-1:0]         index_a;
		logic [IDX_W-1:0]         index_b;
		logic [IDX_W-1:0]         index_c;
		logic [IDX_W-1:0]         index_inner;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} in_word_t;

	typedef struct packed {
		logic                     kind;
		logic [IDX_W-1:0]         out_a;
		logic [IDX_W-1:0]         out_b;
		logic [IDX_W-1:0]         out_c;
		logic                     flipped;
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
	} out_word_t;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] x;
		logic signed [NORM_W-1:0] y;
		logic signed [NORM_W-1:0] z;
	} nvec_t;

endpackage

>>> rtl/mvna_unit.sv
module mvna_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mvna_pkg::vec_t    vin,
	output logic              done,
	output mvna_pkg::nvec_t   nout
);
	import mvna_pkg::*;

	localparam logic [3:0] U_IDLE = 4'd0;
	localparam logic [3:0] U_UP   = 4'd1;
	localparam logic [3:0] U_DN   = 4'd2;
	localparam logic [3:0] U_SQ   = 4'd3;
	localparam logic [3:0] U_SUM  = 4'd4;
	localparam logic [3:0] U_RT   = 4'd5;
	localparam logic [3:0] U_DVS  = 4'd6;
	localparam logic [3:0] U_DV   = 4'd7;
	localparam logic [3:0] U_FIN  = 4'd8;

	logic [3:0]  st_q;
	logic [63:0] m_q [3];
	logic [2:0]  neg_q;
	logic [63:0] p_q [3];
	logic [63:0] s_q, res_q, bit_q;
	logic [1:0]  k_q;
	logic [63:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic [15:0] q_q [3];
	logic [63:0] big;
	logic [63:0] trial;
	logic [63:0] rem_n;

	always_comb begin
		big = m_q[0];
		if (m_q[1] > big) big = m_q[1];
		if (m_q[2] > big) big = m_q[2];
		trial = res_q + bit_q;
		rem_n = {rem_q[62:0], quo_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= U_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				U_IDLE: if (start) begin
					neg_q <= {vin.z[63], vin.y[63], vin.x[63]};
					m_q[0] <= vin.x[63] ? -vin.x : vin.x;
					m_q[1] <= vin.y[63] ? -vin.y : vin.y;
					m_q[2] <= vin.z[63] ? -vin.z : vin.z;
					st_q <= U_DN;
				end
				U_DN: begin
					if (big == 64'd0) begin
						q_q[0] <= '0; q_q[1] <= '0; q_q[2] <= '0;
						st_q <= U_FIN;
					end else if (big[63:30] != '0) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else st_q <= U_UP;
				end
				U_UP: begin
					if (big[29] == 1'b0) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						k_q <= 2'd0;
						st_q <= U_SQ;
					end
				end
				U_SQ: begin
					p_q[k_q] <= m_q[k_q][31:0] * m_q[k_q][31:0];
					if (k_q == 2'd2) st_q <= U_SUM;
					else k_q <= k_q + 2'd1;
				end
				U_SUM: begin
					s_q <= p_q[0] + p_q[1] + p_q[2];
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
					st_q <= U_RT;
				end
				U_RT: begin
					if (s_q >= trial) begin
						s_q <= s_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else res_q <= res_q >> 1;
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						k_q <= 2'd0;
						st_q <= U_DVS;
					end
				end
				U_DVS: begin
					quo_q <= {m_q[k_q][49:0], 14'd0} + {1'b0, res_q[63:1]};
					den_q <= res_q;
					rem_q <= '0;
					cnt_q <= 6'd0;
					st_q <= U_DV;
				end
				U_DV: begin
					if (rem_n >= den_q) begin
						rem_q <= rem_n - den_q;
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_n;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						st_q <= (k_q == 2'd2) ? U_FIN : U_DVS;
						q_q[k_q] <= (rem_n >= den_q) ? {quo_q[14:0], 1'b1}
							: {quo_q[14:0], 1'b0};
						k_q <= k_q + 2'd1;
					end
				end
				U_FIN: begin
					nout.x <= neg_q[0] ? -q_q[0] : q_q[0];
					nout.y <= neg_q[1] ? -q_q[1] : q_q[1];
					nout.z <= neg_q[2] ? -q_q[2] : q_q[2];
					done <= 1'b1;
					st_q <= U_IDLE;
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/mesh_vertex_normal_accumulate_top.sv
// Vertex normal accumulator. Vertex positions and per-vertex normal sums live in two
// single-port synchronous memories. Write and clear items give no result; a face gives
// a report with its unit normal, a read gives the renormalized sum. Faces and reads
// go through the shared iterative square root (32 steps) and the 64-step bit-serial
// divider run once per component, plus the normalizing shifts; a zero vector skips
// both. A vertex write is taken without leaving the idle state. A result waiting at the
// output holds the block only when the next result is ready. After reset and after
// every clear item the sum memory is swept one entry per cycle over all DEPTH
// entries (VERTEX_COUNT capped at 1024), during which no item is taken.
module mesh_vertex_normal_accumulate_top #(
	parameter int VERTEX_COUNT = 1024,
	parameter int SUM_WIDTH = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mvna_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output mvna_pkg::out_word_t out_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [0:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import mvna_pkg::*;

	localparam int DEPTH = (VERTEX_COUNT < (1 << IDX_W)) ? VERTEX_COUNT : (1 << IDX_W);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = SUM_WIDTH;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_LD    = 4'd2;
	localparam logic [3:0] S_LDW   = 4'd3;
	localparam logic [3:0] S_CROSS = 4'd4;
	localparam logic [3:0] S_NORM  = 4'd5;
	localparam logic [3:0] S_DOT   = 4'd6;
	localparam logic [3:0] S_FLIP  = 4'd7;
	localparam logic [3:0] S_ACR   = 4'd8;
	localparam logic [3:0] S_ACW   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;
	localparam logic [3:0] S_RDR   = 4'd11;
	localparam logic [3:0] S_RDW   = 4'd12;

	logic [3*COORD_W-1:0] vmem [DEPTH];
	logic [3*SW-1:0]      smem [DEPTH];
	logic [3*COORD_W-1:0] vrd_q;
	logic [3*SW-1:0]      srd_q;

	logic        orient_q;
	logic [3:0]  st_q;
	logic [AW:0] clr_q;
	in_word_t    it_q;
	logic [2:0]  k_q;
	logic signed [COORD_W-1:0] pv_q [4][3];
	logic signed [COORD_W:0]   u_q [3], w_q [3];
	logic signed [63:0] pr_q [6];
	logic signed [63:0] d_q;
	vec_t        cv_q;
	logic        ustart_q;
	logic        udone;
	nvec_t       un;
	nvec_t       n_q;
	logic        flip_q;
	logic [IDX_W-1:0] b_q, c_q;
	logic        ovalid_q;
	out_word_t   ow_q;
	logic        vwe, swe;
	logic [AW-1:0] vaddr, saddr;
	logic [3*SW-1:0] swd;
	logic [IDX_W-1:0] cidx;
	logic [IDX_W-1:0] vidx;
	logic        accept;
	logic        out_free;
	logic signed [SW+1:0] acc [3];
	logic [3*SW-1:0] accw;

	assign pready = 1'b1;
	assign prdata = {31'd0, orient_q};
	assign in_stall = (st_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !ovalid_q || !out_stall;
	assign out_valid = ovalid_q;
	assign out_word = ow_q;

	mvna_unit u_norm (
		.clk(clk), .arst_n(arst_n), .start(ustart_q), .vin(cv_q),
		.done(udone), .nout(un)
	);

	always_comb begin
		case (k_q[1:0])
			2'd0: vidx = it_q.index_a;
			2'd1: vidx = it_q.index_b;
			2'd2: vidx = it_q.index_c;
			default: vidx = it_q.index_inner;
		endcase
		case (k_q[1:0])
			2'd0: cidx = it_q.index_a;
			2'd1: cidx = b_q;
			default: cidx = c_q;
		endcase
		acc[0] = $signed({srd_q[3*SW-1], srd_q[3*SW-1], srd_q[3*SW-1 -: SW]}) + n_q.x;
		acc[1] = $signed({srd_q[2*SW-1], srd_q[2*SW-1], srd_q[2*SW-1 -: SW]}) + n_q.y;
		acc[2] = $signed({srd_q[SW-1], srd_q[SW-1], srd_q[SW-1 -: SW]}) + n_q.z;
		for (int i = 0; i < 3; i++) begin
			if (acc[i] > $signed({3'b000, {(SW-1){1'b1}}}))
				accw[(2-i)*SW +: SW] = {1'b0, {(SW-1){1'b1}}};
			else if (acc[i] < -$signed({3'b001, {(SW-1){1'b0}}}))
				accw[(2-i)*SW +: SW] = {1'b1, {(SW-1){1'b0}}};
			else accw[(2-i)*SW +: SW] = acc[i][SW-1:0];
		end
		vwe = accept && in_word.opcode == OP_WRITE
			&& {22'd0, in_word.index_a} < 32'(VERTEX_COUNT);
		vaddr = vwe ? in_word.index_a[AW-1:0] : vidx[AW-1:0];
		swe = 1'b0;
		saddr = cidx[AW-1:0];
		swd = accw;
		if (st_q == S_CLR) begin
			swe = 1'b1;
			saddr = clr_q[AW-1:0];
			swd = '0;
		end else if (st_q == S_ACW) begin
			swe = {22'd0, cidx} < 32'(VERTEX_COUNT);
		end else if (st_q == S_RDR || st_q == S_IDLE) begin
			saddr = it_q.index_a[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (vwe) vmem[vaddr] <= {in_word.coord_x, in_word.coord_y, in_word.coord_z};
		vrd_q <= vmem[vaddr];
		if (swe) smem[saddr] <= swd;
		srd_q <= smem[saddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= 1'b0;
			st_q <= S_CLR;
			clr_q <= '0;
			ovalid_q <= 1'b0;
			ustart_q <= 1'b0;
			k_q <= '0;
		end else begin
			ustart_q <= 1'b0;
			if (psel && penable && pwrite && paddr == 1'b0) orient_q <= pwdata[0];
			if (ovalid_q && !out_stall && st_q != S_OUT) ovalid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (accept) begin
					it_q <= in_word;
					k_q <= '0;
					unique case (in_word.opcode)
						OP_WRITE: st_q <= S_IDLE;
						OP_CLEAR: begin
							clr_q <= '0;
							st_q <= S_CLR;
						end
						OP_FACE:  st_q <= S_LD;
						default:  st_q <= S_RDR;
					endcase
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DEPTH - 1)) st_q <= S_IDLE;
				end
				S_LD: st_q <= S_LDW;
				S_LDW: begin
					pv_q[k_q[1:0]][0] <= ({22'd0, vidx} < 32'(VERTEX_COUNT))
						? vrd_q[3*COORD_W-1 -: COORD_W] : '0;
					pv_q[k_q[1:0]][1] <= ({22'd0, vidx} < 32'(VERTEX_COUNT))
						? vrd_q[2*COORD_W-1 -: COORD_W] : '0;
					pv_q[k_q[1:0]][2] <= ({22'd0, vidx} < 32'(VERTEX_COUNT))
						? vrd_q[COORD_W-1 -: COORD_W] : '0;
					if (k_q == 3'd3) begin
						k_q <= '0;
						st_q <= S_CROSS;
					end else begin
						k_q <= k_q + 3'd1;
						st_q <= S_LD;
					end
				end
				S_CROSS: begin
					k_q <= k_q + 3'd1;
					unique case (k_q)
						3'd0: for (int i = 0; i < 3; i++) begin
							u_q[i] <= pv_q[1][i] - pv_q[0][i];
							w_q[i] <= pv_q[2][i] - pv_q[0][i];
						end
						3'd1: begin
							pr_q[0] <= 64'(u_q[1] * w_q[2]);
							pr_q[1] <= 64'(u_q[2] * w_q[1]);
						end
						3'd2: begin
							pr_q[2] <= 64'(u_q[2] * w_q[0]);
							pr_q[3] <= 64'(u_q[0] * w_q[2]);
						end
						3'd3: begin
							pr_q[4] <= 64'(u_q[0] * w_q[1]);
							pr_q[5] <= 64'(u_q[1] * w_q[0]);
						end
						default: begin
							cv_q.x <= pr_q[0] - pr_q[1];
							cv_q.y <= pr_q[2] - pr_q[3];
							cv_q.z <= pr_q[4] - pr_q[5];
							ustart_q <= 1'b1;
							st_q <= S_NORM;
						end
					endcase
				end
				S_NORM: if (udone) begin
					n_q <= un;
					b_q <= it_q.index_b;
					c_q <= it_q.index_c;
					flip_q <= 1'b0;
					k_q <= '0;
					st_q <= (it_q.opcode == OP_FACE) ? S_DOT : S_OUT;
				end
				S_DOT: begin
					k_q <= k_q + 3'd1;
					unique case (k_q)
						3'd0: begin
							pr_q[0] <= 64'(n_q.x * (pv_q[3][0] - pv_q[0][0]));
							pr_q[1] <= 64'(n_q.y * (pv_q[3][1] - pv_q[0][1]));
							pr_q[2] <= 64'(n_q.z * (pv_q[3][2] - pv_q[0][2]));
						end
						default: begin
							d_q <= pr_q[0] + pr_q[1] + pr_q[2];
							st_q <= S_FLIP;
						end
					endcase
				end
				S_FLIP: begin
					if (orient_q && d_q > 64'sd0) begin
						n_q.x <= -n_q.x; n_q.y <= -n_q.y; n_q.z <= -n_q.z;
						b_q <= c_q;
						c_q <= b_q;
						flip_q <= 1'b1;
					end
					k_q <= '0;
					st_q <= S_ACR;
				end
				S_ACR: st_q <= S_ACW;
				S_ACW: begin
					if (k_q == 3'd2) st_q <= S_OUT;
					else begin
						k_q <= k_q + 3'd1;
						st_q <= S_ACR;
					end
				end
				S_OUT: if (out_free) begin
					ow_q.kind <= (it_q.opcode == OP_READ);
					ow_q.out_a <= it_q.index_a;
					ow_q.out_b <= (it_q.opcode == OP_READ) ? '0 : b_q;
					ow_q.out_c <= (it_q.opcode == OP_READ) ? '0 : c_q;
					ow_q.flipped <= (it_q.opcode == OP_READ) ? 1'b0 : flip_q;
					ow_q.normal_x <= n_q.x;
					ow_q.normal_y <= n_q.y;
					ow_q.normal_z <= n_q.z;
					ovalid_q <= 1'b1;
					st_q <= S_IDLE;
				end
				S_RDR: st_q <= S_RDW;
				S_RDW: begin
					if ({22'd0, it_q.index_a} < 32'(VERTEX_COUNT)) begin
						cv_q.x <= 64'($signed(srd_q[3*SW-1 -: SW]));
						cv_q.y <= 64'($signed(srd_q[2*SW-1 -: SW]));
						cv_q.z <= 64'($signed(srd_q[SW-1 -: SW]));
					end else cv_q <= '0;
					ustart_q <= 1'b1;
					st_q <= S_NORM;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
